@@ sv/mtm_pkg.sv @@
// Shared constants for the muscle torque model: register map and index width.
package mtm_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONIC_STIFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST_POSITION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REFLEX_WEIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COCONTR   = 3'd7;

endpackage

@@ sv/mtm_regs.sv @@
// Configuration register file of the muscle torque model.
module mtm_regs #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mtm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]             i_cfg_data,
    output logic signed [DATA_WIDTH-1:0]      o_active_gain,
    output logic signed [DATA_WIDTH-1:0]      o_stiffness_gain,
    output logic signed [DATA_WIDTH-1:0]      o_tonic_stiffness,
    output logic signed [DATA_WIDTH-1:0]      o_damping_gain,
    output logic signed [DATA_WIDTH-1:0]      o_rest_position,
    output logic        [DATA_WIDTH-2:0]      o_torque_limit,
    output logic        [DATA_WIDTH-2:0]      o_reflex_weight,
    output logic signed [DATA_WIDTH-1:0]      o_base_cocontraction
);
    import mtm_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_alpha;
    logic signed [DATA_WIDTH-1:0] r_beta;
    logic signed [DATA_WIDTH-1:0] r_gamma;
    logic signed [DATA_WIDTH-1:0] r_delta;
    logic signed [DATA_WIDTH-1:0] r_rest;
    logic        [DATA_WIDTH-2:0] r_limit;
    logic        [DATA_WIDTH-2:0] r_weight;
    logic signed [DATA_WIDTH-1:0] r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= '0;
            r_beta   <= '0;
            r_gamma  <= '0;
            r_delta  <= '0;
            r_rest   <= '0;
            r_limit  <= '1;
            r_weight <= '0;
            r_base   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACTIVE_GAIN:    r_alpha  <= i_cfg_data;
                REG_STIFFNESS_GAIN: r_beta   <= i_cfg_data;
                REG_TONIC_STIFF:    r_gamma  <= i_cfg_data;
                REG_DAMPING_GAIN:   r_delta  <= i_cfg_data;
                REG_REST_POSITION:  r_rest   <= i_cfg_data;
                REG_TORQUE_LIMIT:   r_limit  <= i_cfg_data[DATA_WIDTH-2:0];
                REG_REFLEX_WEIGHT:  r_weight <= i_cfg_data[DATA_WIDTH-2:0];
                REG_BASE_COCONTR:   r_base   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_active_gain        = r_alpha;
    assign o_stiffness_gain     = r_beta;
    assign o_tonic_stiffness    = r_gamma;
    assign o_damping_gain       = r_delta;
    assign o_rest_position      = r_rest;
    assign o_torque_limit       = r_limit;
    assign o_reflex_weight      = r_weight;
    assign o_base_cocontraction = r_base;

endmodule

@@ sv/muscle_torque_model.sv @@
// Top level of the muscle torque model: six-stage fixed-point torque pipeline.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------------
//   input     | i_valid / o_stall      | agonist, antagonist, target, measured pos,
//             |                        | measured velocity, cocontraction scale
//   output    | o_valid / i_stall      | torque, four terms, torque_clipped
//   config    | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
//
// One item per clock unless stalled; four dependent multiplies (cocontraction,
// gain, reflex, alpha) plus the final sum and clamp set the stages. Synchronous
// active-low reset clears the stage valid bits and sets the config registers
// (limit to all ones, others to zero). A stall holds the output; each stage
// fills its own bubble, so o_stall rises only once every stage holds an item.
module muscle_torque_model #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [DATA_WIDTH-1:0]      i_agonist_drive,
    input  logic signed [DATA_WIDTH-1:0]      i_antagonist_drive,
    input  logic signed [DATA_WIDTH-1:0]      i_target_position,
    input  logic signed [DATA_WIDTH-1:0]      i_measured_position,
    input  logic signed [DATA_WIDTH-1:0]      i_measured_velocity,
    input  logic signed [DATA_WIDTH-1:0]      i_cocontraction_scale,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [DATA_WIDTH-1:0]      o_torque,
    output logic signed [DATA_WIDTH-1:0]      o_active_term,
    output logic signed [DATA_WIDTH-1:0]      o_reflex_term,
    output logic signed [DATA_WIDTH-1:0]      o_elastic_term,
    output logic signed [DATA_WIDTH-1:0]      o_viscous_term,
    output logic                              o_torque_clipped,
    input  logic                              i_cfg_we,
    input  logic [mtm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]             i_cfg_data
);
    import mtm_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS;
    localparam logic signed [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_Q = W'(1) << F;
    localparam logic signed [W-1:0] NEG_ONE_Q = -ONE_Q;

    function automatic logic signed [W-1:0] qsat(input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] s;
        s = p >>> F;
        if ((&s[2*W-1:W-1]) || !(|s[2*W-1:W-1])) begin
            return s[W-1:0];
        end
        return s[2*W-1] ? VMIN : VMAX;
    endfunction

    function automatic logic signed [W-1:0] sat1(input logic signed [W:0] v);
        if (v[W] == v[W-1]) begin
            return v[W-1:0];
        end
        return v[W] ? VMIN : VMAX;
    endfunction

    function automatic logic signed [W-1:0] sat3(input logic signed [W+2:0] v);
        if ((&v[W+2:W-1]) || !(|v[W+2:W-1])) begin
            return v[W-1:0];
        end
        return v[W+2] ? VMIN : VMAX;
    endfunction

    logic signed [W-1:0] w_alpha, w_beta, w_gamma, w_delta, w_rest, w_base;
    logic        [W-2:0] w_limit, w_weight;

    mtm_regs #(
        .DATA_WIDTH (W)
    ) u_regs (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_active_gain        (w_alpha),
        .o_stiffness_gain     (w_beta),
        .o_tonic_stiffness    (w_gamma),
        .o_damping_gain       (w_delta),
        .o_rest_position      (w_rest),
        .o_torque_limit       (w_limit),
        .o_reflex_weight      (w_weight),
        .o_base_cocontraction (w_base)
    );

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !r_v6 || !i_stall;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // stage 1
    logic signed [2*W-1:0] r_s1_p_coc, r_s1_p_visc;
    logic signed [W-1:0]   r_s1_d_act, r_s1_d_err, r_s1_d_rest;
    logic signed [W:0]     r_s1_agant;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_p_coc  <= (2*W)'(w_base) * (2*W)'(i_cocontraction_scale);
            r_s1_p_visc <= (2*W)'(w_delta) * (2*W)'(i_measured_velocity);
            r_s1_d_act  <= sat1((W+1)'(i_agonist_drive) - (W+1)'(i_antagonist_drive));
            r_s1_d_err  <= sat1((W+1)'(i_target_position) - (W+1)'(i_measured_position));
            r_s1_d_rest <= sat1((W+1)'(w_rest) - (W+1)'(i_measured_position));
            r_s1_agant  <= (W+1)'(i_agonist_drive) + (W+1)'(i_antagonist_drive);
        end
    end

    // stage 2
    logic signed [W-1:0]   n_coc, n_weight_s;
    logic signed [W+2:0]   n_esum;
    logic signed [2*W-1:0] r_s2_p_act, r_s2_p_gain;
    logic signed [W-1:0]   r_s2_esum, r_s2_visc, r_s2_d_err, r_s2_d_rest;

    assign n_coc      = qsat(r_s1_p_coc);
    assign n_weight_s = signed'({1'b0, w_weight});
    assign n_esum     = (W+3)'(r_s1_agant) + ((W+3)'(n_coc) <<< 1) + (W+3)'(w_gamma);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_p_act  <= (2*W)'(w_alpha) * (2*W)'(r_s1_d_act);
            r_s2_p_gain <= (2*W)'(n_weight_s) * (2*W)'(n_coc);
            r_s2_esum   <= sat3(n_esum);
            r_s2_visc   <= qsat(r_s1_p_visc);
            r_s2_d_err  <= r_s1_d_err;
            r_s2_d_rest <= r_s1_d_rest;
        end
    end

    // stage 3
    logic signed [W-1:0]   n_gain;
    logic signed [2*W-1:0] r_s3_p_rx, r_s3_p_el1;
    logic signed [W-1:0]   r_s3_act, r_s3_visc, r_s3_d_rest;

    assign n_gain = qsat(r_s2_p_gain);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_p_rx   <= (2*W)'(n_gain) * (2*W)'(r_s2_d_err);
            r_s3_p_el1  <= (2*W)'(w_beta) * (2*W)'(r_s2_esum);
            r_s3_act    <= qsat(r_s2_p_act);
            r_s3_visc   <= r_s2_visc;
            r_s3_d_rest <= r_s2_d_rest;
        end
    end

    // stage 4
    logic signed [W-1:0]   n_rx_raw, n_rx, n_el1;
    logic signed [2*W-1:0] r_s4_p_ref, r_s4_p_el2;
    logic signed [W-1:0]   r_s4_act, r_s4_visc;

    assign n_rx_raw = qsat(r_s3_p_rx);
    assign n_el1    = qsat(r_s3_p_el1);

    always_comb begin
        if (n_rx_raw > ONE_Q) begin
            n_rx = ONE_Q;
        end else if (n_rx_raw < NEG_ONE_Q) begin
            n_rx = NEG_ONE_Q;
        end else begin
            n_rx = n_rx_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_p_ref <= (2*W)'(w_alpha) * (2*W)'(n_rx);
            r_s4_p_el2 <= (2*W)'(n_el1) * (2*W)'(r_s3_d_rest);
            r_s4_act   <= r_s3_act;
            r_s4_visc  <= r_s3_visc;
        end
    end

    // stage 5
    logic signed [W-1:0] n_ref, n_el;
    logic signed [W-1:0] r_s5_act, r_s5_ref, r_s5_el, r_s5_visc;
    logic signed [W+1:0] r_s5_sum;

    assign n_ref = qsat(r_s4_p_ref);
    assign n_el  = qsat(r_s4_p_el2);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_act  <= r_s4_act;
            r_s5_ref  <= n_ref;
            r_s5_el   <= n_el;
            r_s5_visc <= r_s4_visc;
            r_s5_sum  <= (W+2)'(r_s4_act) + (W+2)'(n_ref) + (W+2)'(n_el)
                         + (W+2)'(r_s4_visc);
        end
    end

    // stage 6
    logic signed [W+1:0] n_lim_pos, n_lim_neg;
    logic signed [W-1:0] n_torque;
    logic                n_clip;
    logic signed [W-1:0] r_s6_torque, r_s6_act, r_s6_ref, r_s6_el, r_s6_visc;
    logic                r_s6_clip;

    assign n_lim_pos = signed'({3'b000, w_limit});
    assign n_lim_neg = -n_lim_pos;

    always_comb begin
        if (r_s5_sum > n_lim_pos) begin
            n_torque = n_lim_pos[W-1:0];
            n_clip   = 1'b1;
        end else if (r_s5_sum < n_lim_neg) begin
            n_torque = n_lim_neg[W-1:0];
            n_clip   = 1'b1;
        end else begin
            n_torque = r_s5_sum[W-1:0];
            n_clip   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_s6_torque <= n_torque;
            r_s6_clip   <= n_clip;
            r_s6_act    <= r_s5_act;
            r_s6_ref    <= r_s5_ref;
            r_s6_el     <= r_s5_el;
            r_s6_visc   <= r_s5_visc;
        end
    end

    assign o_valid          = r_v6;
    assign o_torque         = r_s6_torque;
    assign o_active_term    = r_s6_act;
    assign o_reflex_term    = r_s6_ref;
    assign o_elastic_term   = r_s6_el;
    assign o_viscous_term   = r_s6_visc;
    assign o_torque_clipped = r_s6_clip;

endmodule
